@@ rtl/core/mss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and codes for the masked search stack: request and response
// payloads, request type codes and the per-cell control word.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int TYPE_BITS     = 3;
    localparam int DATA_BITS     = 32;
    localparam int POS_BITS      = 5;
    localparam int SCAN_GROUP    = 8;
    localparam int SCAN_SEL_BITS = 3;

    // request types
    localparam logic [TYPE_BITS-1:0] REQ_PUSH  = 3'd0;
    localparam logic [TYPE_BITS-1:0] REQ_POP   = 3'd1;
    localparam logic [TYPE_BITS-1:0] REQ_FIND  = 3'd2;
    localparam logic [TYPE_BITS-1:0] REQ_READ  = 3'd3;
    localparam logic [TYPE_BITS-1:0] REQ_WRITE = 3'd4;
    localparam logic [TYPE_BITS-1:0] REQ_CLEAR = 3'd5;

    // cell operations
    localparam logic [2:0] CELL_HOLD  = 3'd0;
    localparam logic [2:0] CELL_DOWN  = 3'd1;
    localparam logic [2:0] CELL_UP    = 3'd2;
    localparam logic [2:0] CELL_WRITE = 3'd3;
    localparam logic [2:0] CELL_CLEAR = 3'd4;

    typedef struct packed {
        logic [TYPE_BITS-1:0] req_type;
        logic [DATA_BITS-1:0] value;
        logic [DATA_BITS-1:0] mask;
        logic [POS_BITS-1:0]  position;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic [DATA_BITS-1:0] read_value;
        logic [POS_BITS-1:0]  found_at;
        logic [POS_BITS-1:0]  fill_count;
    } t_rsp;

    typedef struct packed {
        logic [2:0]          op;
        logic [POS_BITS-1:0] pos;
    } t_cell_ctl;

endpackage

@@ rtl/core/mss_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_if
// Valid/ready channels for stack requests and stack responses.
// ----------------------------------------------------------------------------
interface mss_req_if
    import mss_pkg::*;
    ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mss_rsp_if
    import mss_pkg::*;
    ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/mss_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_cell
// One stack entry: shifts from its neighbors, takes a positional write,
// clears, and compares its masked word against the search key.
// ----------------------------------------------------------------------------
module mss_cell
    import mss_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_prev,
    input  logic [WORD_BITS-1:0] i_next,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [WORD_BITS-1:0] i_key,
    input  logic [WORD_BITS-1:0] i_mask,
    output logic [WORD_BITS-1:0] o_data,
    output logic                 o_match
);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 w_sel;

    // positions are 1-based
    assign w_sel = (32'(i_ctl.pos) == 32'(IDX + 1));

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_DOWN:  n_data = i_prev;
            CELL_UP:    n_data = i_next;
            CELL_WRITE: if (w_sel) n_data = i_wdata;
            CELL_CLEAR: n_data = '0;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data  = r_data;
    assign o_match = ((r_data & i_mask) == i_key);

endmodule

@@ rtl/core/mss_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_scan
// First-match search over the latched match vector, one group of cells
// per cycle from the top of the stack down.
// ----------------------------------------------------------------------------
module mss_scan
    import mss_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEPTH-1:0] i_match,
    output logic             o_done,
    output logic [CW-1:0]    o_found
);

    localparam int NG   = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int PADW = NG * SCAN_GROUP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;

    logic                     r_busy;
    logic [PADW-1:0]          r_vec;
    logic [GW-1:0]            r_grp;
    logic [CW-1:0]            r_base;
    logic [SCAN_GROUP-1:0]    w_bits;
    logic [SCAN_SEL_BITS-1:0] w_enc;
    logic                     w_hit;
    logic                     w_last;

    assign w_bits = r_vec[SCAN_GROUP-1:0];
    assign w_hit  = |w_bits;
    assign w_last = (r_grp == GW'(NG - 1));

    // lowest set bit wins: that is the topmost matching entry
    always_comb begin
        w_enc = '0;
        for (int i = SCAN_GROUP - 1; i >= 0; i--) begin
            if (w_bits[i]) w_enc = SCAN_SEL_BITS'(i);
        end
    end

    assign o_done  = r_busy && (w_hit || w_last);
    assign o_found = w_hit ? (r_base + CW'(w_enc) + CW'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end else begin
                r_grp <= r_grp + GW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec  <= PADW'(i_match);
            r_base <= '0;
        end else if (r_busy) begin
            r_vec  <= r_vec >> SCAN_GROUP;
            r_base <= r_base + CW'(SCAN_GROUP);
        end
    end

endmodule

@@ rtl/core/masked_search_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_search_stack
// Shift-register stack with masked content search and positional access.
// ----------------------------------------------------------------------------
// Entries live in a chain of cells, entry 1 on top; push and pop shift the
// whole chain together, and every cell compares its masked word against the
// key at the same time. Push, pop, read, write, clear and unknown types answer
// straight from the request without a scan. A find latches all cell compares
// and then walks the match vector eight cells per cycle, stopping early when a
// match turns up (a find on an empty stack answers without a scan).
// One request is in flight at a time; the response sits in an output register
// and the next request is taken as soon as that register is empty or being
// drained. Reset zeroes every cell at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module masked_search_stack
    import mss_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mss_req_if.sink     i_req,
    mss_rsp_if.source   o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = (CW > POS_BITS) ? CW + 1 : POS_BITS + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 r_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic                 w_acc;
    logic                 w_ready;
    logic [WORD_BITS-1:0] w_val;
    logic [WORD_BITS-1:0] w_msk;
    logic [EW-1:0]        w_pos_e;
    logic [EW-1:0]        w_cnt_e;
    logic [IW-1:0]        w_ridx;
    t_cell_ctl            w_ctl;
    t_rsp                 w_rsp;
    logic                 w_start;
    logic                 w_imm;

    logic [WORD_BITS-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]     w_match;
    logic [DEPTH-1:0]     w_valid;
    logic                 w_done;
    logic [CW-1:0]        w_found;

    assign w_ready     = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = w_ready;
    assign w_acc       = i_req.valid && w_ready;

    assign w_val   = WORD_BITS'(i_req.payload.value);
    assign w_msk   = WORD_BITS'(i_req.payload.mask);
    assign w_pos_e = EW'(i_req.payload.position);
    assign w_cnt_e = EW'(r_count);
    assign w_ridx  = IW'(w_pos_e - EW'(1));

    always_comb begin
        w_ctl.op   = CELL_HOLD;
        w_ctl.pos  = i_req.payload.position;
        n_count    = r_count;
        w_start    = 1'b0;
        w_imm      = 1'b1;
        w_rsp      = '0;
        case (i_req.payload.req_type)
            REQ_PUSH: begin
                if (r_count < CW'(DEPTH)) begin
                    w_ctl.op = CELL_DOWN;
                    n_count  = r_count + CW'(1);
                    w_rsp.ok = 1'b1;
                end
            end
            REQ_POP: begin
                if (r_count != '0) begin
                    w_ctl.op         = CELL_UP;
                    n_count          = r_count - CW'(1);
                    w_rsp.ok         = 1'b1;
                    w_rsp.read_value = DATA_BITS'(w_data[0]);
                end
            end
            REQ_FIND: begin
                // non-empty find hands over to the scan unit
                if (r_count != '0) begin
                    w_start = 1'b1;
                    w_imm   = 1'b0;
                end
            end
            REQ_READ: begin
                if (w_pos_e != '0 && w_pos_e <= w_cnt_e) begin
                    w_rsp.ok         = 1'b1;
                    w_rsp.read_value = DATA_BITS'(w_data[w_ridx]);
                end
            end
            REQ_WRITE: begin
                if (w_pos_e != '0 && w_pos_e <= EW'(DEPTH)) begin
                    w_ctl.op = CELL_WRITE;
                    w_rsp.ok = 1'b1;
                    if (w_pos_e > w_cnt_e) n_count = CW'(w_pos_e);
                end
            end
            REQ_CLEAR: begin
                w_ctl.op = CELL_CLEAR;
                n_count  = '0;
                w_rsp.ok = 1'b1;
            end
            default: begin
                w_rsp.ok = 1'b0;
            end
        endcase
        w_rsp.fill_count = POS_BITS'(n_count);
        if (!w_acc) begin
            w_ctl.op = CELL_HOLD;
            w_start  = 1'b0;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_prev;
        logic [WORD_BITS-1:0] w_next;

        if (g == 0) begin : g_top
            assign w_prev = w_val;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_bot
            assign w_next = '0;
        end else begin : g_up
            assign w_next = w_data[g+1];
        end

        assign w_valid[g] = (32'(g) < 32'(r_count));

        mss_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_wdata (w_val),
            .i_key   (w_val),
            .i_mask  (w_msk),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    mss_scan #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_match (w_match & w_valid),
        .o_done  (w_done),
        .o_found (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) r_count <= n_count;
            case (r_state)
                ST_IDLE: if (w_start) r_state <= ST_SCAN;
                ST_SCAN: if (w_done) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
            if ((w_acc && w_imm) || w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_imm) begin
            r_out <= w_rsp;
        end else if (w_done) begin
            r_out.ok         <= 1'b1;
            r_out.read_value <= '0;
            r_out.found_at   <= POS_BITS'(w_found);
            r_out.fill_count <= POS_BITS'(r_count);
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

@@ rtl/core/mss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks on the masked search stack responses.
// ----------------------------------------------------------------------------
module mss_checker
    import mss_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic [TYPE_BITS-1:0] i_req_type,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic                 i_rsp_ok,
    input logic [DATA_BITS-1:0] i_rsp_read_value,
    input logic [POS_BITS-1:0]  i_rsp_found_at,
    input logic [POS_BITS-1:0]  i_rsp_fill_count
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_ok)
        && $stable(i_rsp_read_value) && $stable(i_rsp_found_at)
        && $stable(i_rsp_fill_count))
        else $error("response changed while stalled");

    // a hit lies within the valid entries
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_found_at != '0 |->
        i_rsp_ok && i_rsp_found_at <= i_rsp_fill_count)
        else $error("found position outside the stack");

    // data only comes back on a successful pop or read
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_read_value != '0 |-> i_rsp_ok)
        else $error("read data on a rejected request");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_rsp_fill_count) <= 32'(DEPTH))
        else $error("fill count beyond depth");

    // clear answers in the next cycle with an empty stack
    a_clear_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_type == REQ_CLEAR |=>
        i_rsp_valid && i_rsp_ok && i_rsp_fill_count == '0
        && i_rsp_found_at == '0 && i_rsp_read_value == '0)
        else $error("clear response wrong");

endmodule

bind masked_search_stack mss_checker #(
    .DEPTH (DEPTH)
) u_mss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_type       (i_req.payload.req_type),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_ok         (o_rsp.payload.ok),
    .i_rsp_read_value (o_rsp.payload.read_value),
    .i_rsp_found_at   (o_rsp.payload.found_at),
    .i_rsp_fill_count (o_rsp.payload.fill_count)
);

@@ tb/masked_search_stack_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_search_stack_test
// Self-checking bench for the masked search stack. Requests go in through the
// request channel. A local copy of the stack predicts every response: push,
// pop, masked find, read, write, clear and the unused types. Each response is
// checked field by field against the oldest prediction. Both channels idle
// and stall at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module masked_search_stack_test;
    import mss_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 300;

    // request types that the block ignores
    localparam logic [TYPE_BITS-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [TYPE_BITS-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic [DATA_BITS-1:0] ALL_ONES = '1;

    logic clk;
    logic rst_n;

    mss_req_if req_ch ();
    mss_rsp_if rsp_ch ();

    masked_search_stack #(
        .DEPTH     (STACK_DEPTH),
        .WORD_BITS (DATA_BITS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // local copy of the stack
    logic [DATA_BITS-1:0] stack_words [STACK_DEPTH];
    int unsigned          stack_fill;

    t_rsp pending_rsps [$];
    int   failures;
    int   cycle_count;

    int source_idle_pct;
    int sink_idle_pct;
    int hold_token;
    int hold_seen;
    int hold_left;

    initial begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    initial begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        failures       = 0;
        cycle_count    = 0;
        stack_fill     = 0;
        source_idle_pct = 0;
        sink_idle_pct  = 0;
        hold_token     = 0;
        hold_seen      = 0;
        hold_left      = 0;
        foreach (stack_words[i]) stack_words[i] = '0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("masked_search_stack_test failed");
            $finish;
        end
    end

    // apply one request to the local stack and return the response it gives
    function automatic t_rsp stack_apply(input t_req r);
        t_rsp rsp;
        rsp = '0;
        case (r.req_type)
            REQ_PUSH: begin
                if (stack_fill < STACK_DEPTH) begin
                    for (int i = STACK_DEPTH - 1; i > 0; i--) stack_words[i] = stack_words[i-1];
                    stack_words[0] = r.value;
                    stack_fill++;
                    rsp.ok = 1'b1;
                end
            end
            REQ_POP: begin
                if (stack_fill > 0) begin
                    rsp.read_value = stack_words[0];
                    for (int i = 0; i < STACK_DEPTH - 1; i++) stack_words[i] = stack_words[i+1];
                    stack_words[STACK_DEPTH-1] = '0;
                    stack_fill--;
                    rsp.ok = 1'b1;
                end
            end
            REQ_FIND: begin
                if (stack_fill > 0) begin
                    rsp.ok = 1'b1;
                    for (int i = 0; i < stack_fill; i++) begin
                        if (rsp.found_at == 0 && (stack_words[i] & r.mask) == r.value)
                            rsp.found_at = POS_BITS'(i + 1);
                    end
                end
            end
            REQ_READ: begin
                if (r.position >= 1 && r.position <= stack_fill) begin
                    rsp.read_value = stack_words[r.position - 1];
                    rsp.ok = 1'b1;
                end
            end
            REQ_WRITE: begin
                if (r.position >= 1 && r.position <= STACK_DEPTH) begin
                    stack_words[r.position - 1] = r.value;
                    if (r.position > stack_fill) stack_fill = r.position;
                    rsp.ok = 1'b1;
                end
            end
            REQ_CLEAR: begin
                foreach (stack_words[i]) stack_words[i] = '0;
                stack_fill = 0;
                rsp.ok = 1'b1;
            end
            default: begin
            end
        endcase
        rsp.fill_count = POS_BITS'(stack_fill);
        return rsp;
    endfunction

    // predict on each accepted request, check each accepted response
    always @(posedge clk) begin
        t_rsp want;
        t_rsp got;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) pending_rsps.push_back(stack_apply(req_ch.payload));
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.payload;
                if (pending_rsps.size() == 0) begin
                    $error("response with no request outstanding: %p", got);
                    failures++;
                end else begin
                    want = pending_rsps.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        failures++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               got.read_value);
                        failures++;
                    end
                    if (got.found_at !== want.found_at) begin
                        $error("found_at: expected %0d, got %0d", want.found_at,
                               got.found_at);
                        failures++;
                    end
                    if (got.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               got.fill_count);
                        failures++;
                    end
                end
            end
        end
    end

    // response side: random stalls plus a long hold-off on each hold_token change
    always @(negedge clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < source_idle_pct) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    function automatic t_req make_req(input logic [TYPE_BITS-1:0] kind,
                                      input logic [DATA_BITS-1:0] value,
                                      input logic [DATA_BITS-1:0] mask,
                                      input logic [POS_BITS-1:0] position);
        t_req r;
        r.req_type = kind;
        r.value    = value;
        r.mask     = mask;
        r.position = position;
        return r;
    endfunction

    function automatic logic [DATA_BITS-1:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3, 4: return 32'hA5A5_0000 | $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_BITS-1:0] random_mask();
        case ($urandom_range(19))
            0:                return '0;
            1, 2, 3:          return DATA_BITS'(1) << $urandom_range(DATA_BITS - 1);
            4, 5, 6, 7, 8, 9: return $urandom;
            default:          return ALL_ONES;
        endcase
    endfunction

    // mostly sensible requests against the current stack, some noise
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   top_pos;
        pick       = $urandom_range(99);
        r.value    = random_word();
        r.mask     = random_mask();
        top_pos    = (stack_fill < STACK_DEPTH) ? stack_fill + 1 : STACK_DEPTH;
        r.position = ($urandom_range(3) == 0) ? POS_BITS'($urandom_range(31))
                                               : POS_BITS'($urandom_range(1, top_pos));
        if (pick < 30) r.req_type = REQ_PUSH;
        else if (pick < 48) r.req_type = REQ_POP;
        else if (pick < 68) r.req_type = REQ_FIND;
        else if (pick < 80) r.req_type = REQ_READ;
        else if (pick < 91) r.req_type = REQ_WRITE;
        else if (pick < 95) r.req_type = REQ_CLEAR;
        else r.req_type = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        // key taken from a live entry so that finds hit at varied depths
        if (r.req_type == REQ_FIND && stack_fill > 0 && $urandom_range(9) < 6)
            r.value = stack_words[$urandom_range(stack_fill - 1)] & r.mask;
        return r;
    endfunction

    task automatic set_idling(input int source_pct, input int sink_pct);
        source_idle_pct = source_pct;
        sink_idle_pct  <= sink_pct;
    endtask

    task automatic test_corner_cases();
        send_request(make_req(REQ_POP,   '0, '0, 5'd0));
        send_request(make_req(REQ_FIND,  '0, '0, 5'd0));
        send_request(make_req(REQ_READ,  '0, '0, 5'd1));
        send_request(make_req(REQ_PUSH,  '0, '0, 5'd0));
        send_request(make_req(REQ_PUSH,  ALL_ONES, '0, 5'd0));
        send_request(make_req(REQ_PUSH,  32'h1234_5678, '0, 5'd0));
        send_request(make_req(REQ_FIND,  ALL_ONES, ALL_ONES, 5'd0));
        send_request(make_req(REQ_FIND,  32'h0000_5678, 32'h0000_FFFF, 5'd0));
        send_request(make_req(REQ_FIND,  '0, '0, 5'd0));
        send_request(make_req(REQ_FIND,  32'h0000_0001, '0, 5'd0));
        send_request(make_req(REQ_READ,  '0, '0, 5'd0));
        send_request(make_req(REQ_READ,  '0, '0, 5'd3));
        send_request(make_req(REQ_READ,  '0, '0, 5'd4));
        send_request(make_req(REQ_READ,  '0, '0, 5'd31));
        send_request(make_req(REQ_WRITE, 32'h5555_AAAA, '0, 5'd0));
        send_request(make_req(REQ_WRITE, 32'h5555_AAAA, '0, 5'd17));
        // write at the bottom skips over zero entries and fills the stack
        send_request(make_req(REQ_WRITE, 32'hDEAD_BEEF, '0, 5'd16));
        send_request(make_req(REQ_READ,  '0, '0, 5'd10));
        send_request(make_req(REQ_READ,  '0, '0, 5'd16));
        send_request(make_req(REQ_PUSH,  32'hCAFE_F00D, '0, 5'd0));
        send_request(make_req(REQ_POP,   '0, '0, 5'd0));
        send_request(make_req(REQ_SPARE_LO, ALL_ONES, ALL_ONES, 5'd1));
        send_request(make_req(REQ_SPARE_HI, ALL_ONES, ALL_ONES, 5'd31));
        send_request(make_req(REQ_CLEAR, '0, '0, 5'd0));
        send_request(make_req(REQ_POP,   '0, '0, 5'd0));
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_back_pressure();
        set_idling(0, 0);
        hold_token <= hold_token + 1;
        repeat (24) send_request(random_request());
    endtask

    task automatic test_random_traffic(input int source_pct, input int sink_pct);
        set_idling(source_pct, sink_pct);
        repeat (RANDOM_ITEMS) send_request(random_request());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_cases();
        test_back_pressure();
        test_random_traffic(32, 58);
        test_random_traffic(58, 32);
        test_random_traffic(0, 0);

        req_ch.valid  <= 1'b0;
        sink_idle_pct <= 0;
        while (pending_rsps.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0) begin
            $display("masked_search_stack_test passed");
        end else begin
            $display("masked_search_stack_test failed");
        end
        $finish;
    end

endmodule

@@ masked_search_stack.f @@
rtl/core/mss_pkg.sv
rtl/core/mss_if.sv
rtl/core/mss_cell.sv
rtl/core/mss_scan.sv
rtl/core/masked_search_stack.sv
rtl/core/mss_checker.sv
tb/masked_search_stack_test.sv
